### design/ahfe_pkg.sv
// ----------------------------------------------------------------------------
// ahfe_pkg
// Types, constants and helpers shared by the ASCII hex frame encoder.
// ----------------------------------------------------------------------------
package ahfe_pkg;

    localparam int unsigned CHUNK_BYTES_DEF = 80;

    localparam logic [7:0] CMD_CODE   = 8'h01;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_EMPTY = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] dest_id;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       frame_end;
        logic       run_last;
    } t_out;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] data;
        logic [7:0] ck1;
        logic       hdr_a;
        logic       has_byte;
        logic       close_a;
        logic       tail;
    } t_job;

    typedef enum logic [2:0] {
        PH_HDR_A,
        PH_BYTE,
        PH_CLOSE_A,
        PH_HDR_B,
        PH_CLOSE_B,
        PH_DONE
    } t_phase;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else begin
            r = 8'h41 + {4'h0, v - 4'd10};
        end
        return r;
    endfunction

endpackage

### design/ahfe_front.sv
// ----------------------------------------------------------------------------
// ahfe_front
// Accepts message bytes, tracks frame state and issues one frame job per request, bar empty requests mid-message.
// ----------------------------------------------------------------------------
module ahfe_front #(
    parameter int unsigned CHUNK_BYTES = ahfe_pkg::CHUNK_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ahfe_pkg::t_in  i_in_data,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output ahfe_pkg::t_job o_push_job
);
    import ahfe_pkg::*;

    localparam int unsigned CNT_W = $clog2(CHUNK_BYTES + 1);

    logic             r_frame_open, n_frame_open;
    logic [CNT_W-1:0] r_bytes, n_bytes;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_latched_id, n_latched_id;
    logic             r_in_message, n_in_message;

    logic             eff_open;
    logic [7:0]       lid;
    logic [7:0]       base_sum;
    logic [7:0]       s1;
    logic [CNT_W-1:0] new_cnt;
    logic             full;
    logic             drop;
    logic             accept;

    assign o_in_ready   = i_push_ready;
    assign accept       = i_in_valid && i_push_ready;
    assign drop         = (i_in_data.kind == KIND_EMPTY) && r_in_message;
    assign o_push_valid = i_in_valid && !drop;

    always_comb begin
        eff_open = r_in_message && r_frame_open;
        lid      = r_in_message ? r_latched_id : i_in_data.dest_id;
        base_sum = eff_open ? r_sum : lid + CMD_CODE;
        new_cnt  = (eff_open ? r_bytes : '0) + CNT_W'(1);
        full     = new_cnt >= CNT_W'(CHUNK_BYTES);
        s1       = base_sum + i_in_data.data_byte;

        o_push_job.id   = lid;
        o_push_job.data = i_in_data.data_byte;
        if (i_in_data.kind == KIND_EMPTY) begin
            o_push_job.ck1      = 8'h00 - base_sum;
            o_push_job.hdr_a    = 1'b1;
            o_push_job.has_byte = 1'b0;
            o_push_job.close_a  = 1'b1;
            o_push_job.tail     = 1'b0;
        end else begin
            o_push_job.ck1      = 8'h00 - s1;
            o_push_job.hdr_a    = !eff_open;
            o_push_job.has_byte = 1'b1;
            o_push_job.close_a  = full || i_in_data.last_byte;
            o_push_job.tail     = full && i_in_data.last_byte;
        end
    end

    always_comb begin
        n_frame_open = r_frame_open;
        n_bytes      = r_bytes;
        n_sum        = r_sum;
        n_latched_id = r_latched_id;
        n_in_message = r_in_message;
        if (accept && !drop) begin
            n_latched_id = lid;
            if (i_in_data.kind == KIND_EMPTY || i_in_data.last_byte) begin
                n_in_message = 1'b0;
                n_frame_open = 1'b0;
                n_bytes      = '0;
                n_sum        = '0;
            end else begin
                n_in_message = 1'b1;
                if (full) begin
                    n_frame_open = 1'b0;
                    n_bytes      = '0;
                    n_sum        = '0;
                end else begin
                    n_frame_open = 1'b1;
                    n_bytes      = new_cnt;
                    n_sum        = s1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_bytes      <= '0;
            r_sum        <= '0;
            r_latched_id <= '0;
            r_in_message <= 1'b0;
        end else begin
            r_frame_open <= n_frame_open;
            r_bytes      <= n_bytes;
            r_sum        <= n_sum;
            r_latched_id <= n_latched_id;
            r_in_message <= n_in_message;
        end
    end

endmodule

### design/ahfe_queue.sv
// ----------------------------------------------------------------------------
// ahfe_queue
// Two-entry job queue between the front and the character sequencer.
// ----------------------------------------------------------------------------
module ahfe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  ahfe_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output ahfe_pkg::t_job o_pop_job
);
    import ahfe_pkg::*;

    t_job       r_mem [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_count, n_count;
    logic       push;
    logic       pop;

    assign o_push_ready = r_count != 2'd2;
    assign o_pop_valid  = r_count != 2'd0;
    assign o_pop_job    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_comb begin
        n_wr    = push ? !r_wr : r_wr;
        n_rd    = pop ? !r_rd : r_rd;
        n_count = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

### design/ahfe_back.sv
// ----------------------------------------------------------------------------
// ahfe_back
// Walks a frame job through its segments and emits one ASCII character per cycle while not stalled.
// ----------------------------------------------------------------------------
module ahfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  ahfe_pkg::t_job i_pop_job,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ahfe_pkg::t_out o_out_data
);
    import ahfe_pkg::*;

    t_phase     r_phase, n_phase;
    logic [2:0] r_pos, n_pos;
    t_job       r_job, n_job;
    logic       r_out_valid, n_out_valid;
    t_out       r_out, n_out;

    t_phase     after;
    t_phase     start;
    logic [2:0] seg_last;
    logic       seg_end;
    logic       emit;
    logic       job_done;
    logic       load;
    logic [7:0] ck2;
    logic [7:0] ch;
    logic       fe;

    // character generation and segment sequencing
    always_comb begin
        ck2 = 8'h00 - (r_job.id + CMD_CODE);
        ch  = CHAR_COLON;
        fe  = 1'b0;
        unique case (r_phase)
            PH_HDR_A, PH_HDR_B: begin
                seg_last = 3'd4;
                case (r_pos)
                    3'd0:    ch = CHAR_COLON;
                    3'd1:    ch = hex_digit(r_job.id[7:4]);
                    3'd2:    ch = hex_digit(r_job.id[3:0]);
                    3'd3:    ch = hex_digit(CMD_CODE[7:4]);
                    default: ch = hex_digit(CMD_CODE[3:0]);
                endcase
            end
            PH_BYTE: begin
                seg_last = 3'd1;
                ch = (r_pos == 3'd0) ? hex_digit(r_job.data[7:4]) : hex_digit(r_job.data[3:0]);
            end
            PH_CLOSE_A, PH_CLOSE_B: begin
                seg_last = 3'd3;
                case (r_pos)
                    3'd0: ch = hex_digit(r_phase == PH_CLOSE_A ? r_job.ck1[7:4] : ck2[7:4]);
                    3'd1: ch = hex_digit(r_phase == PH_CLOSE_A ? r_job.ck1[3:0] : ck2[3:0]);
                    3'd2: ch = CHAR_CR;
                    default: begin
                        ch = CHAR_LF;
                        fe = 1'b1;
                    end
                endcase
            end
            default: seg_last = 3'd0;
        endcase

        unique case (r_phase)
            PH_HDR_A:   after = r_job.has_byte ? PH_BYTE : PH_CLOSE_A;
            PH_BYTE:    after = r_job.close_a ? PH_CLOSE_A : PH_DONE;
            PH_CLOSE_A: after = r_job.tail ? PH_HDR_B : PH_DONE;
            PH_HDR_B:   after = PH_CLOSE_B;
            default:    after = PH_DONE;
        endcase

        start       = i_pop_job.hdr_a ? PH_HDR_A : PH_BYTE;
        seg_end     = r_pos == seg_last;
        emit        = (r_phase != PH_DONE) && (!r_out_valid || i_out_ready);
        job_done    = emit && seg_end && (after == PH_DONE);
        load        = i_pop_valid && ((r_phase == PH_DONE) || job_done);
        o_pop_ready = load;
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_job   = r_job;
        if (load) begin
            n_phase = start;
            n_pos   = 3'd0;
            n_job   = i_pop_job;
        end else if (emit) begin
            if (seg_end) begin
                n_phase = after;
                n_pos   = 3'd0;
            end else begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid     = 1'b1;
            n_out.out_char  = ch;
            n_out.frame_end = fe;
            n_out.run_last  = job_done;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DONE;
            r_pos       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### design/ascii_hex_frame_encoder.sv
// ----------------------------------------------------------------------------
// ascii_hex_frame_encoder
// Turns message bytes into ':'-framed upper-case hex frames with checksum.
// ----------------------------------------------------------------------------
// The output port moves one ASCII character per cycle when it is not stalled,
// and that port sets the rate: a data byte costs 2 to 20 characters (2 in an
// open frame, 7 when it opens a frame, up to 20 when it also closes a full frame
// and appends the empty end frame), an empty message 9 characters, and an empty
// request inside a message is taken with no output. The front takes a new request
// every cycle while its two-entry job queue has room, so input and output stall
// independently; a request passes the queue entry, job and output registers.
module ascii_hex_frame_encoder #(
    parameter int unsigned CHUNK_BYTES = ahfe_pkg::CHUNK_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ahfe_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ahfe_pkg::t_out o_out_data
);
    import ahfe_pkg::*;

    logic push_valid;
    logic push_ready;
    t_job push_job;
    logic pop_valid;
    logic pop_ready;
    t_job pop_job;

    ahfe_front #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_push_valid(push_valid),
        .i_push_ready(push_ready),
        .o_push_job  (push_job)
    );

    ahfe_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(push_valid),
        .o_push_ready(push_ready),
        .i_push_job  (push_job),
        .o_pop_valid (pop_valid),
        .i_pop_ready (pop_ready),
        .o_pop_job   (pop_job)
    );

    ahfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop_valid(pop_valid),
        .o_pop_ready(pop_ready),
        .i_pop_job  (pop_job),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

### design/ahfe_checker.sv
// ----------------------------------------------------------------------------
// ahfe_checker
// Port-level checks on the encoder's character stream, bound to the top level.
// ----------------------------------------------------------------------------
module ahfe_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input ahfe_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ahfe_pkg::t_out o_out_data
);
    import ahfe_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("request dropped or changed while stalled");

    a_lf_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |-> o_out_data.out_char == CHAR_LF)
        else $error("frame end not on line feed");

    a_colon_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_char == CHAR_COLON |-> !o_out_data.run_last)
        else $error("frame start closes a request");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> !$isunknown(i_in_data))
        else $error("unknown input accepted");

endmodule

bind ascii_hex_frame_encoder ahfe_checker u_ahfe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

### verif/ahfe_frame_checker.sv
// ----------------------------------------------------------------------------
// ahfe_frame_checker
// Watches both channels of the ASCII hex frame encoder. Each accepted request
// is expanded into the characters it must cause: frame header, payload hex
// digits, checksum and line end. Each accepted character is checked field by
// field against the oldest of them. The failure count and the number of
// characters still awaited go back to the testbench top.
// ----------------------------------------------------------------------------
module ahfe_frame_checker #(
    parameter int unsigned CHUNK_BYTES = ahfe_pkg::CHUNK_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  ahfe_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  ahfe_pkg::t_out i_out_data,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ahfe_pkg::*;

    logic       frm_open;
    logic [6:0] frm_bytes;
    logic [7:0] frm_sum;
    logic [7:0] msg_id;
    logic       msg_active;
    t_out       expected_chars[$];
    int         fail_total = 0;

    function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h37 + {4'h0, v};
    endfunction

    task automatic push_char(input logic [7:0] c, input logic fe);
        t_out ch;
        ch.out_char  = c;
        ch.frame_end = fe;
        ch.run_last  = 1'b0;
        expected_chars.push_back(ch);
    endtask

    task automatic push_hex(input logic [7:0] b);
        push_char(nibble_ascii(b[7:4]), 1'b0);
        push_char(nibble_ascii(b[3:0]), 1'b0);
    endtask

    task automatic start_frame();
        push_char(CHAR_COLON, 1'b0);
        push_hex(msg_id);
        push_hex(CMD_CODE);
        frm_sum   = msg_id + CMD_CODE;
        frm_bytes = '0;
        frm_open  = 1'b1;
    endtask

    task automatic end_frame();
        push_hex(8'h00 - frm_sum);
        push_char(CHAR_CR, 1'b0);
        push_char(CHAR_LF, 1'b1);
        frm_open  = 1'b0;
        frm_bytes = '0;
        frm_sum   = '0;
    endtask

    task automatic encode_request(input t_in r);
        int base;
        base = expected_chars.size();
        if (r.kind == KIND_EMPTY) begin
            if (!msg_active) begin
                msg_id = r.dest_id;
                start_frame();
                end_frame();
            end
        end else begin
            if (!msg_active) begin
                msg_id     = r.dest_id;
                msg_active = 1'b1;
                frm_open   = 1'b0;
                frm_bytes  = '0;
                frm_sum    = '0;
            end
            if (!frm_open) begin
                start_frame();
            end
            push_hex(r.data_byte);
            frm_sum   = frm_sum + r.data_byte;
            frm_bytes = frm_bytes + 7'd1;
            if (frm_bytes >= CHUNK_BYTES) begin
                end_frame();
            end
            if (r.last_byte) begin
                if (frm_open) begin
                    end_frame();
                end else begin
                    start_frame();
                    end_frame();
                end
                msg_active = 1'b0;
            end
        end
        if (expected_chars.size() > base) begin
            expected_chars[expected_chars.size() - 1].run_last = 1'b1;
        end
    endtask

    task automatic check_char(input t_out got);
        t_out exp_ch;
        if (expected_chars.size() == 0) begin
            $error("unexpected character %02h with nothing awaited", got.out_char);
            fail_total++;
        end else begin
            exp_ch = expected_chars.pop_front();
            if (got.out_char !== exp_ch.out_char) begin
                $error("out_char expected %02h got %02h", exp_ch.out_char, got.out_char);
                fail_total++;
            end
            if (got.frame_end !== exp_ch.frame_end) begin
                $error("frame_end expected %0b got %0b", exp_ch.frame_end, got.frame_end);
                fail_total++;
            end
            if (got.run_last !== exp_ch.run_last) begin
                $error("run_last expected %0b got %0b", exp_ch.run_last, got.run_last);
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frm_open   = 1'b0;
            frm_bytes  = '0;
            frm_sum    = '0;
            msg_id     = '0;
            msg_active = 1'b0;
            expected_chars.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                encode_request(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                check_char(i_out_data);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_chars.size();
    end

endmodule

### verif/tb_ascii_hex_frame_encoder.sv
// ----------------------------------------------------------------------------
// tb_ascii_hex_frame_encoder
// Drives the ASCII hex frame encoder with directed and random messages.
// Directed requests cover empty messages, single-byte messages, extreme ids
// and bytes, a zero checksum and empty requests inside a message. Random
// messages follow, some at and past the chunk size, with random gaps on the
// request side, random stalls on the character side and two long stalls that
// back the encoder up. The checker instance predicts and compares.
// ----------------------------------------------------------------------------
module tb_ascii_hex_frame_encoder;
    timeunit 1ns;
    timeprecision 1ps;
    import ahfe_pkg::*;

    localparam int unsigned CHUNK       = CHUNK_BYTES_DEF;
    localparam int          MSG_ITEMS   = 480;
    localparam longint      CYCLE_LIMIT = 2_000_000;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   req_valid = 1'b0;
    logic   req_ready;
    t_in    req_data  = '0;
    logic   chr_valid;
    logic   chr_ready = 1'b0;
    t_out   chr_data;
    int     fail_count;
    int     pending;
    longint cycles    = 0;
    int     items_sent;

    always #1 clk = ~clk;

    ascii_hex_frame_encoder #(
        .CHUNK_BYTES (CHUNK)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (chr_valid),
        .i_out_ready (chr_ready),
        .o_out_data  (chr_data)
    );

    ahfe_frame_checker #(
        .CHUNK_BYTES (CHUNK)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_ready   (req_ready),
        .i_in_data    (req_data),
        .i_out_valid  (chr_valid),
        .i_out_ready  (chr_ready),
        .i_out_data   (chr_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_in mk_req(input logic k, input logic [7:0] id,
                                   input logic [7:0] b, input logic lst);
        t_in r;
        r.kind      = k;
        r.dest_id   = id;
        r.data_byte = b;
        r.last_byte = lst;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_req(input t_in r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic send_message(input int len, input logic [7:0] id);
        for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 99) < 5) begin
                send_req(mk_req(KIND_EMPTY, 8'($urandom), 8'($urandom), 1'($urandom)));
            end
            send_req(mk_req(KIND_DATA, (i == 0) ? id : 8'($urandom), 8'($urandom),
                            i == len - 1));
            items_sent++;
        end
    endtask

    initial begin
        int rounds;
        int burst;
        int gap;
        int r;
        rounds = 0;
        do @(posedge clk); while (!rst_n);
        forever begin
            r = $urandom_range(0, 99);
            burst = (r < 10) ? $urandom_range(60, 150) : $urandom_range(1, 12);
            chr_ready <= 1'b1;
            repeat (burst) @(posedge clk);
            rounds++;
            r = $urandom_range(0, 99);
            if (rounds == 60 || rounds == 250) begin
                gap = 400;
            end else if (r < 40) begin
                gap = 0;
            end else if (r < 88) begin
                gap = $urandom_range(1, 3);
            end else begin
                gap = $urandom_range(10, 30);
            end
            if (gap > 0) begin
                chr_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial begin
        int r;
        int len;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(mk_req(KIND_EMPTY, 8'h00, 8'h00, 1'b0));
        send_req(mk_req(KIND_EMPTY, 8'hFF, 8'hFF, 1'b1));
        send_req(mk_req(KIND_DATA,  8'h00, 8'h00, 1'b1));
        send_req(mk_req(KIND_DATA,  8'hFF, 8'hFF, 1'b1));
        send_req(mk_req(KIND_DATA,  8'hFE, 8'h01, 1'b1));
        send_req(mk_req(KIND_DATA,  8'hA5, 8'h3C, 1'b0));
        send_req(mk_req(KIND_EMPTY, 8'h12, 8'h34, 1'b1));
        send_req(mk_req(KIND_DATA,  8'h5A, 8'hC3, 1'b0));
        send_req(mk_req(KIND_EMPTY, 8'h00, 8'h00, 1'b0));
        send_req(mk_req(KIND_DATA,  8'h00, 8'h00, 1'b1));
        send_req(mk_req(KIND_DATA,  8'h7F, 8'h80, 1'b1));
        send_req(mk_req(KIND_DATA,  8'h80, 8'h7F, 1'b1));
        send_req(mk_req(KIND_EMPTY, 8'h01, 8'hAA, 1'b0));
        send_req(mk_req(KIND_DATA,  8'hFE, 8'h01, 1'b0));
        send_req(mk_req(KIND_DATA,  8'h33, 8'hFE, 1'b0));
        send_req(mk_req(KIND_DATA,  8'hCC, 8'hFF, 1'b1));
        send_req(mk_req(KIND_DATA,  8'h55, 8'h0F, 1'b0));
        send_req(mk_req(KIND_DATA,  8'hAA, 8'hF0, 1'b1));
        send_req(mk_req(KIND_EMPTY, 8'h55, 8'h55, 1'b1));

        send_message(CHUNK, 8'($urandom));
        send_message(CHUNK + 1, 8'($urandom));
        while (items_sent < MSG_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_req(mk_req(KIND_EMPTY, 8'($urandom), 8'($urandom), 1'($urandom)));
                items_sent++;
            end else begin
                if (r < 75) begin
                    len = $urandom_range(1, 8);
                end else if (r < 88) begin
                    len = $urandom_range(9, 40);
                end else if (r < 97) begin
                    len = $urandom_range(CHUNK - 1, CHUNK + 1);
                end else begin
                    len = 2 * CHUNK;
                end
                if (len > MSG_ITEMS - items_sent) begin
                    len = MSG_ITEMS - items_sent;
                end
                send_message(len, 8'($urandom));
            end
        end
        req_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (24) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
